### rtl/srn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srn_pkg: shared types and constants of the slice range normalizer
// Widths of the slice fields, the internal arithmetic width and the
// payload that travels down the divider cell chain.
// ----------------------------------------------------------------------------
package srn_pkg;

  // Width of the signed slice bounds and of the step.
  localparam int unsigned INDEX_WIDTH = 32;
  // Width of the container length and of the index and count results.
  localparam int unsigned LEN_W = 31;
  // Signed width that holds a bound plus the length without overflow.
  localparam int unsigned AW = ((INDEX_WIDTH > LEN_W) ? INDEX_WIDTH : LEN_W + 1) + 1;
  // Signed width of a clamped bound, which lies in [-1, length].
  localparam int unsigned CW = LEN_W + 1;
  // One divider cell per quotient bit.
  localparam int unsigned NUM_CELLS = LEN_W;

  typedef logic [LEN_W-1:0]              len_t;
  typedef logic signed [INDEX_WIDTH-1:0] idx_t;
  typedef logic [INDEX_WIDTH-1:0]        mag_t;
  typedef logic signed [AW-1:0]          wide_t;
  typedef logic signed [CW-1:0]          bound_t;

  // Payload of one divider cell: partial remainder, numerator bits still to
  // be consumed with quotient bits shifted in behind them, the divisor, and
  // the side results that ride along.
  typedef struct packed {
    mag_t rem;
    len_t nq;
    mag_t divisor;
    len_t first;
    logic empty;
    logic err;
  } div_t;

endpackage

### rtl/srn_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srn_in_if: slice descriptor channel
// Valid/ready channel that carries the container length and a raw slice.
// ----------------------------------------------------------------------------
interface srn_in_if;
  import srn_pkg::*;

  logic valid;
  logic ready;
  len_t length;
  idx_t start_index;
  logic start_given;
  idx_t stop_index;
  logic stop_given;
  idx_t stride;

  modport source (
    output valid, length, start_index, start_given, stop_index, stop_given, stride,
    input  ready
  );

  modport sink (
    input  valid, length, start_index, start_given, stop_index, stop_given, stride,
    output ready
  );
endinterface

### rtl/srn_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srn_out_if: normalized slice result channel
// Valid/ready channel that carries the first index, count and flags.
// ----------------------------------------------------------------------------
interface srn_out_if;
  import srn_pkg::*;

  logic valid;
  logic ready;
  len_t first_index;
  len_t element_count;
  logic is_empty;
  logic step_error;

  modport source (
    output valid, first_index, element_count, is_empty, step_error,
    input  ready
  );

  modport sink (
    input  valid, first_index, element_count, is_empty, step_error,
    output ready
  );
endinterface

### rtl/slice_range_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slice_range_normalizer: Python-style slice normalization
// Each beat on slice_i carries a container length and a slice (start, stop,
// step, with flags for omitted bounds); each beat on result_o returns the
// first selected index, the number of selected elements, an empty flag and
// a zero-step error flag, one result per descriptor and in order. The block
// takes one descriptor every clock cycle while the sink keeps taking results,
// and holds a fully pipelined path of 34 register stages: two for wrapping and
// clamping the bounds, one cell per quotient bit (31 cells) for the division of
// the span by the step magnitude, and the output register. Every stage stalls on
// its own, so bubbles close up and a new descriptor is taken while a finished
// result waits.
// ----------------------------------------------------------------------------
module slice_range_normalizer (
  input  logic    clk_i,
  input  logic    rst_ni,
  srn_in_if.sink  slice_i,
  srn_out_if.source result_o
);
  import srn_pkg::*;

  // Handshake and payload between neighboring stages of the cell chain.
  logic cell_valid [NUM_CELLS+1];
  logic cell_ready [NUM_CELLS+1];
  div_t cell_data  [NUM_CELLS+1];

  srn_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .slice_i (slice_i),
    .valid_o (cell_valid[0]),
    .ready_i (cell_ready[0]),
    .data_o  (cell_data[0])
  );

  // Each cell resolves one quotient bit, most significant first.
  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    srn_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_valid[c]),
      .ready_o (cell_ready[c]),
      .data_i  (cell_data[c]),
      .valid_o (cell_valid[c+1]),
      .ready_i (cell_ready[c+1]),
      .data_o  (cell_data[c+1])
    );
  end

  srn_finish u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (cell_valid[NUM_CELLS]),
    .ready_o  (cell_ready[NUM_CELLS]),
    .data_i   (cell_data[NUM_CELLS]),
    .result_o (result_o)
  );

  // A zero step reports an error and nothing else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.step_error |->
      !result_o.is_empty && result_o.element_count == '0 && result_o.first_index == '0)
    else $error("step error beat carries nonzero fields");

  // An empty slice selects nothing and points at index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.is_empty |->
      result_o.element_count == '0 && result_o.first_index == '0)
    else $error("empty slice beat carries a count or index");

  // A valid nonempty slice selects at least one element.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.is_empty && !result_o.step_error |->
      result_o.element_count != '0)
    else $error("nonempty slice beat with zero count");

  // A beat stalled at the end of the divider chain stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[NUM_CELLS] && !cell_ready[NUM_CELLS] |=>
      cell_valid[NUM_CELLS] && $stable(cell_data[NUM_CELLS]))
    else $error("divider chain dropped or changed a stalled beat");
endmodule

### rtl/srn_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srn_prep: bound normalization front end
// Two pipeline stages: wrap and clamp both bounds, then form the empty flag
// and the numerator and divisor for the divider chain.
// ----------------------------------------------------------------------------
module srn_prep (
  input  logic            clk_i,
  input  logic            rst_ni,
  srn_in_if.sink          slice_i,
  output logic            valid_o,
  input  logic            ready_i,
  output srn_pkg::div_t   data_o
);
  import srn_pkg::*;

  localparam wide_t WIDE_ONE = wide_t'(1);
  localparam wide_t WIDE_M1  = '1;
  localparam wide_t WIDE_Z   = '0;

  typedef struct packed {
    bound_t start;
    bound_t stop;
    mag_t   mag;
    logic   pos;
    logic   err;
    logic   zlen;
  } bnd_t;

  logic  v1_q, v2_q;
  logic  rdy1, rdy2;
  bnd_t  b_d, b_q;
  div_t  p_d, p_q;

  // Stage one: defaults, wrap by the length and clamp, for both bounds.
  wide_t s_raw, t_raw, len_w, len_m1;
  wide_t s_b, s_w, s_c, t_b, t_w, t_c;
  logic  pos;

  always_comb begin
    s_raw  = {{(AW-INDEX_WIDTH){slice_i.start_index[INDEX_WIDTH-1]}}, slice_i.start_index};
    t_raw  = {{(AW-INDEX_WIDTH){slice_i.stop_index[INDEX_WIDTH-1]}}, slice_i.stop_index};
    len_w  = {{(AW-LEN_W){1'b0}}, slice_i.length};
    len_m1 = len_w - WIDE_ONE;
    pos    = !slice_i.stride[INDEX_WIDTH-1];

    if (pos) begin
      s_b = slice_i.start_given ? s_raw : WIDE_Z;
      s_w = (s_b < WIDE_Z) ? s_b + len_w : s_b;
      s_c = (s_w < WIDE_Z) ? WIDE_Z : ((s_w > len_w) ? len_w : s_w);
      t_b = slice_i.stop_given ? t_raw : len_w;
      t_w = (t_b < WIDE_Z) ? t_b + len_w : t_b;
      t_c = (t_w < WIDE_Z) ? WIDE_Z : ((t_w > len_w) ? len_w : t_w);
    end else begin
      s_b = slice_i.start_given ? s_raw : len_m1;
      s_w = (s_b < WIDE_Z) ? s_b + len_w : s_b;
      s_c = (s_w < WIDE_Z) ? WIDE_M1 : ((s_w >= len_w) ? len_m1 : s_w);
      t_b = t_raw;
      if (!slice_i.stop_given) begin
        t_w = WIDE_M1;
      end else begin
        t_w = (t_b < WIDE_Z) ? t_b + len_w : t_b;
      end
      t_c = (t_w < WIDE_M1) ? WIDE_M1 : ((t_w >= len_w) ? len_m1 : t_w);
    end

    b_d.start = s_c[CW-1:0];
    b_d.stop  = t_c[CW-1:0];
    b_d.mag   = pos ? mag_t'(slice_i.stride) : mag_t'('0) - mag_t'(slice_i.stride);
    b_d.pos   = pos;
    b_d.err   = (slice_i.stride == '0);
    b_d.zlen  = (slice_i.length == '0);
  end

  // Stage two: emptiness and the numerator, which is the span minus one.
  bound_t span_m1;
  logic   empty_raw, empty_f;

  always_comb begin
    if (b_q.pos) begin
      empty_raw = (b_q.start >= b_q.stop);
      span_m1   = b_q.stop - b_q.start - bound_t'(1);
    end else begin
      empty_raw = b_q.start[CW-1] || (b_q.start <= b_q.stop);
      span_m1   = b_q.start - b_q.stop - bound_t'(1);
    end
    empty_f     = !b_q.err && (b_q.zlen || empty_raw);
    p_d.rem     = '0;
    p_d.nq      = (empty_f || b_q.err) ? '0 : span_m1[LEN_W-1:0];
    p_d.divisor = b_q.mag;
    p_d.first   = (empty_f || b_q.err) ? '0 : b_q.start[LEN_W-1:0];
    p_d.empty   = empty_f;
    p_d.err     = b_q.err;
  end

  assign rdy2          = !v2_q || ready_i;
  assign rdy1          = !v1_q || rdy2;
  assign slice_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= slice_i.valid;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && slice_i.valid) b_q <= b_d;
    if (rdy2 && v1_q) p_q <= p_d;
  end

  assign valid_o = v2_q;
  assign data_o  = p_q;
endmodule

### rtl/srn_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srn_div_cell: one restoring division step
// Brings down one numerator bit, subtracts the divisor when it fits and
// shifts the quotient bit in, then registers the result for the next cell.
// ----------------------------------------------------------------------------
module srn_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  srn_pkg::div_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output srn_pkg::div_t  data_o
);
  import srn_pkg::*;

  logic                   valid_q;
  div_t                   data_d, data_q;
  logic [INDEX_WIDTH:0]   trial, diff;
  logic                   fits;

  always_comb begin
    trial       = {data_i.rem, data_i.nq[LEN_W-1]};
    diff        = trial - {1'b0, data_i.divisor};
    fits        = (trial >= {1'b0, data_i.divisor});
    data_d      = data_i;
    data_d.rem  = fits ? diff[INDEX_WIDTH-1:0] : trial[INDEX_WIDTH-1:0];
    data_d.nq   = {data_i.nq[LEN_W-2:0], fits};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

### rtl/srn_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srn_finish: result output register
// Turns the quotient into the element count and holds the result beat
// until the sink takes it.
// ----------------------------------------------------------------------------
module srn_finish (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  srn_pkg::div_t  data_i,
  srn_out_if.source      result_o
);
  import srn_pkg::*;

  logic valid_q;
  len_t first_q, count_q, count_d;
  logic empty_q, err_q;

  // The quotient counts the steps after the first element.
  assign count_d = (data_i.empty || data_i.err) ? '0 : data_i.nq + len_t'(1);
  assign ready_o = !valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      first_q <= data_i.first;
      count_q <= count_d;
      empty_q <= data_i.empty;
      err_q   <= data_i.err;
    end
  end

  assign result_o.valid         = valid_q;
  assign result_o.first_index   = first_q;
  assign result_o.element_count = count_q;
  assign result_o.is_empty      = empty_q;
  assign result_o.step_error    = err_q;
endmodule

### bench/slice_range_normalizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slice_range_normalizer_tb: self-checking bench for the slice normalizer
// A queue of slice descriptors is built up front. It holds a directed set of
// corner cases followed by about a thousand random descriptors. A clocked
// driver offers them on slice_i with random idle bursts. A clocked monitor
// takes results on result_o with random stall bursts and checks every field
// against a behavioral normalizer evaluated when each descriptor is accepted.
// ----------------------------------------------------------------------------
module slice_range_normalizer_tb;
  import srn_pkg::*;

  // Bench constants. The tail is the stretch at the end of the run where
  // neither side idles. The long hold is the one receiver stall that is
  // long enough to back the whole pipeline up into the input.
  localparam int    RANDOM_ITEMS = 1000;
  localparam int    TAIL_ITEMS   = 100;
  localparam int    DRAIN_AT     = 600;
  localparam int    LONG_HOLD    = 200;
  localparam int    LONG_HOLD_AT = 300;
  localparam int    SETTLE_CYCLES = 50;
  localparam longint LEN_MAX = 64'sd2147483647;
  localparam longint IDX_MAX = 64'sd2147483647;
  localparam longint IDX_MIN = -64'sd2147483648;

  // One slice descriptor as it travels on slice_i. The drain flag is bench
  // bookkeeping only: the driver holds this beat back until nothing is in
  // flight any more.
  typedef struct {
    len_t length;
    idx_t start_index;
    logic start_given;
    idx_t stop_index;
    logic stop_given;
    idx_t stride;
    bit   drain_before;
  } slice_item_t;

  // One normalized slice as it comes back on result_o.
  typedef struct {
    len_t first_index;
    len_t element_count;
    logic is_empty;
    logic step_error;
  } slice_result_t;

  logic clk_i;
  logic rst_ni;

  srn_in_if  slice_if ();
  srn_out_if result_if ();

  slice_range_normalizer u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .slice_i  (slice_if),
    .result_o (result_if)
  );

  slice_item_t   pending_slices[$];
  slice_result_t expected_results[$];
  slice_item_t   on_bus;
  slice_result_t want;
  int            send_gap;
  int            hold_left;
  bit            long_hold_done;
  int            results_seen;
  int            mismatch_count;

  // --------------------------------------------------------------------------
  // Behavioral normalizer. All arithmetic runs on 64-bit signed values, so a
  // bound plus the length, and the magnitude of the most negative step, never
  // overflow. Lengths are zero extended and the bounds and step are sign
  // extended on the way in.
  // --------------------------------------------------------------------------
  function automatic slice_result_t normalize_slice(slice_item_t s);
    slice_result_t r;
    longint len;
    longint lo;
    longint hi;
    longint step;
    r    = '{default: '0};
    len  = longint'(s.length);
    lo   = longint'(s.start_index);
    hi   = longint'(s.stop_index);
    step = longint'(s.stride);
    if (step == 0) begin
      // A zero step is an error and every other field stays zero.
      r.step_error = 1'b1;
    end else if (len == 0) begin
      r.is_empty = 1'b1;
    end else if (step > 0) begin
      // Forward walk: omitted bounds default to the whole container, and a
      // negative bound wraps once before clamping into [0, len].
      if (!s.start_given) lo = 0;
      if (!s.stop_given) hi = len;
      if (lo < 0) lo += len;
      if (lo < 0) lo = 0;
      if (lo > len) lo = len;
      if (hi < 0) hi += len;
      if (hi < 0) hi = 0;
      if (hi > len) hi = len;
      if (lo >= hi) begin
        r.is_empty = 1'b1;
      end else begin
        r.first_index   = len_t'(lo);
        r.element_count = len_t'((hi - lo + step - 1) / step);
      end
    end else begin
      // Backward walk: an omitted start is the last element and an omitted
      // stop means one before index zero. Both bounds clamp to [-1, len-1].
      if (!s.start_given) lo = len - 1;
      else if (lo < 0) lo += len;
      if (lo < 0) lo = -1;
      if (lo >= len) lo = len - 1;
      if (!s.stop_given) hi = -1;
      else if (hi < 0) hi += len;
      if (hi < -1) hi = -1;
      if (hi >= len) hi = len - 1;
      if (lo < 0 || lo <= hi) begin
        r.is_empty = 1'b1;
      end else begin
        r.first_index   = len_t'(lo);
        r.element_count = len_t'((lo - hi - 1) / (-step) + 1);
      end
    end
    return r;
  endfunction

  function automatic slice_item_t make_slice(longint len, longint lo, bit lo_given,
                                             longint hi, bit hi_given, longint step);
    slice_item_t s;
    s.length       = len_t'(len);
    s.start_index  = idx_t'(lo);
    s.start_given  = lo_given;
    s.stop_index   = idx_t'(hi);
    s.stop_given   = hi_given;
    s.stride       = idx_t'(step);
    s.drain_before = 1'b0;
    return s;
  endfunction

  // A raw bound for a container of the given length. Most bounds land a few
  // elements around the container so that wrapping and clamping both fire;
  // the rest are extremes, full random words and small values.
  function automatic longint pick_bound(longint len);
    longint v;
    case ($urandom_range(0, 7))
      0: v = longint'($signed($urandom));
      1: v = $urandom_range(0, 1) ? IDX_MAX : IDX_MIN;
      7: v = longint'($urandom_range(0, 10)) - 5;
      default: v = (longint'($urandom) % (2 * len + 7)) - len - 3;
    endcase
    return v;
  endfunction

  // Random descriptor. Short containers dominate so that counts and first
  // indexes stay easy to reason about, but full-width lengths and steps
  // appear often enough to toggle every bit.
  function automatic slice_item_t random_slice();
    longint len;
    longint step;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: len = $urandom_range(0, 20);
      6, 7: len = $urandom_range(0, 1000);
      8: len = longint'($urandom & 32'h7fff_ffff);
      default: len = LEN_MAX - $urandom_range(0, 3);
    endcase
    case ($urandom_range(0, 15))
      0: step = 0;
      1: step = longint'($signed($urandom));
      2: step = $urandom_range(0, 1) ? IDX_MAX : IDX_MIN;
      3, 4, 5, 6, 7, 8: step = $urandom_range(1, 6);
      default: step = -longint'($urandom_range(1, 6));
    endcase
    return make_slice(len, pick_bound(len), $urandom_range(0, 3) != 0,
                      pick_bound(len), $urandom_range(0, 3) != 0, step);
  endfunction

  task automatic check_field(string name, longint exp_val, longint got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, got_val);
      mismatch_count++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Driver. A new descriptor may only replace the one on the bus once that
  // beat has been taken, so the payload stays stable while valid is high.
  // The prediction is made at the edge where the beat is accepted, which
  // keeps the expectation queue in acceptance order.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      slice_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (slice_if.valid && slice_if.ready) begin
        expected_results.push_back(normalize_slice(on_bus));
      end
      if (!slice_if.valid || slice_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          slice_if.valid <= 1'b0;
        end else if (pending_slices.size() == 0 ||
                     (pending_slices[0].drain_before && expected_results.size() != 0)) begin
          // Either nothing is left to send, or the next beat waits until the
          // pipeline has emptied completely.
          slice_if.valid <= 1'b0;
        end else if (pending_slices.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
          // This cycle is the first idle one of the burst.
          send_gap = $urandom_range(1, 14) - 1;
          slice_if.valid <= 1'b0;
        end else begin
          on_bus = pending_slices.pop_front();
          slice_if.valid       <= 1'b1;
          slice_if.length      <= on_bus.length;
          slice_if.start_index <= on_bus.start_index;
          slice_if.start_given <= on_bus.start_given;
          slice_if.stop_index  <= on_bus.stop_index;
          slice_if.stop_given  <= on_bus.stop_given;
          slice_if.stride      <= on_bus.stride;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Every accepted result beat is checked against the oldest
  // expectation. Ready is dropped in random bursts, plus one long hold that
  // lets all 34 stages fill so the block has to push back on its input.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      hold_left = 0;
      long_hold_done = 1'b0;
      results_seen = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual first=%0d count=%0d empty=%0b err=%0b",
                   $time, result_if.first_index, result_if.element_count,
                   result_if.is_empty, result_if.step_error);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("first_index", want.first_index, result_if.first_index);
          check_field("element_count", want.element_count, result_if.element_count);
          check_field("is_empty", want.is_empty, result_if.is_empty);
          check_field("step_error", want.step_error, result_if.step_error);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        result_if.ready <= 1'b0;
      end else if (pending_slices.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 14) - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // --------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    mismatch_count = 0;
    slice_if.valid       = 1'b0;
    slice_if.length      = '0;
    slice_if.start_index = '0;
    slice_if.start_given = 1'b0;
    slice_if.stop_index  = '0;
    slice_if.stop_given  = 1'b0;
    slice_if.stride      = '0;
    result_if.ready      = 1'b0;

    // Directed corner cases: zero step, empty containers, full-width
    // containers walked both ways, the most negative and most positive
    // steps, wrapping and clamping of each bound in each direction, and
    // slices that come out empty.
    pending_slices.push_back(make_slice(10, 0, 1, 10, 1, 0));
    pending_slices.push_back(make_slice(0, 0, 0, 0, 0, 1));
    pending_slices.push_back(make_slice(0, -1, 1, 5, 1, -1));
    pending_slices.push_back(make_slice(LEN_MAX, 0, 0, 0, 0, 1));
    pending_slices.push_back(make_slice(LEN_MAX, 0, 0, 0, 0, -1));
    pending_slices.push_back(make_slice(LEN_MAX, 0, 0, 0, 0, IDX_MIN));
    pending_slices.push_back(make_slice(LEN_MAX, IDX_MIN, 1, IDX_MAX, 1, IDX_MAX));
    pending_slices.push_back(make_slice(LEN_MAX, IDX_MAX, 1, IDX_MIN, 1, -1));
    pending_slices.push_back(make_slice(10, -3, 1, 0, 0, 1));
    pending_slices.push_back(make_slice(10, -30, 1, 4, 1, 1));
    pending_slices.push_back(make_slice(10, 5, 1, 2, 1, 1));
    pending_slices.push_back(make_slice(10, 1, 1, 9, 1, 3));
    pending_slices.push_back(make_slice(10, 0, 1, 0, 1, 5));
    pending_slices.push_back(make_slice(10, 20, 1, 0, 0, -1));
    pending_slices.push_back(make_slice(10, 8, 1, -1, 1, -1));
    pending_slices.push_back(make_slice(10, 8, 1, IDX_MIN, 1, -2));
    pending_slices.push_back(make_slice(10, -11, 1, 0, 0, -1));
    pending_slices.push_back(make_slice(10, 9, 1, 2, 1, -3));
    pending_slices.push_back(make_slice(10, 0, 0, 0, 0, IDX_MIN));
    pending_slices.push_back(make_slice(5, 0, 0, 0, 0, IDX_MAX));
    pending_slices.push_back(make_slice(1, 0, 0, 0, 0, 1));
    pending_slices.push_back(make_slice(1, 0, 0, 0, 0, -1));
    pending_slices.push_back(make_slice(LEN_MAX, -1, 1, 0, 0, 1));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pending_slices.push_back(random_slice());
      // Somewhere in the middle the sender waits for a fully drained block.
      if (i == DRAIN_AT) pending_slices[pending_slices.size() - 1].drain_before = 1'b1;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample on the falling edge so the clocked processes have settled.
    while (pending_slices.size() != 0 || slice_if.valid || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("slice_range_normalizer_tb passed");
    end else begin
      $display("slice_range_normalizer_tb failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("slice_range_normalizer_tb failed");
    $finish;
  end

endmodule
